[rtl/core/slm_pkg.sv]
// Package for the stereo level meter: command codes, table geometry,
// table write request type and the level-to-bar mapping.
// No dependencies.
package slm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam logic [7:0] LEVEL_FULL  = 8'd255;  // raw values past the table
  localparam logic [7:0] PEAK_LEVEL  = 8'd250;  // bar bit 7 lights above this
  localparam logic [7:0] DWELL_RESET = 8'd250;

  typedef enum logic [1:0] {
    CMD_TABLE_WR = 2'd0,
    CMD_SAMPLE   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_FORCE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [7:0]        data;
  } tbl_wr_t;

  // Bits 0..6: thermometer of level>>5; bit 7: peak above PEAK_LEVEL.
  function automatic logic [7:0] bar_of(input logic [7:0] level);
    logic [2:0] q;
    logic [7:0] bits;
    q = level[7:5];
    for (int i = 0; i < 7; i++) begin
      bits[i] = (3'(i) < q);
    end
    bits[7] = (level > PEAK_LEVEL);
    return bits;
  endfunction

endpackage

[rtl/core/slm_if.sv]
// Handshake channel interfaces for the stereo level meter: input items,
// scan results and the configuration write. Depends on slm_pkg.
interface slm_in_if import slm_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] sample;
  logic [5:0] table_index;

  modport source (output valid, cmd, sample, table_index, input ready);
  modport sink   (input valid, cmd, sample, table_index, output ready);
endinterface

interface slm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] row_select;
  logic       left_segment;
  logic       right_segment;

  modport source (output valid, row_select, left_segment, right_segment, input ready);
  modport sink   (input valid, row_select, left_segment, right_segment, output ready);
endinterface

interface slm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] dwell_samples;

  modport source (output valid, dwell_samples, input ready);
  modport sink   (input valid, dwell_samples, output ready);
endinterface

[rtl/core/stereo_level_meter_led_scan.sv]
// Stereo LED level meter with multiplexed bar-graph scan (top level).
// Depends on slm_pkg, slm_if and slm_log_table.
//
// One item per clock is taken on in_chan. An item waits in the input stage,
// where the log table read lands, and is finished as it leaves it; a scan
// tick leaves its row result in the out_chan register, so a tick passes
// through the input stage register and then the out_chan register, which
// drives out_chan.valid, before the row can transfer. The rate is
// one item per cycle, held back only when a tick meets a full output register
// that the sink is not draining. Table writes, samples and forces give no
// result. The table reads undefined until written; a sample of 64 or above
// needs no entry and shows full scale. The dwell register on cfg_chan is
// always ready and should be written while the block is idle.
module stereo_level_meter_led_scan import slm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  slm_in_if.sink    in_chan,
  slm_out_if.source out_chan,
  slm_cfg_if.sink   cfg_chan
);

  // Configuration
  logic [7:0] dwell_samples_r;

  // Input stage
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [7:0] s1_sample_r;

  // Meter state
  logic       on_right_r,    on_right_nxt;
  logic [7:0] dwell_count_r, dwell_count_nxt;
  logic [7:0] left_bar_r,    left_bar_nxt;
  logic [7:0] right_bar_r,   right_bar_nxt;
  logic [7:0] left_shift_r,  left_shift_nxt;
  logic [7:0] right_shift_r, right_shift_nxt;
  logic [2:0] scan_row_r,    scan_row_nxt;

  // Result register
  logic       out_valid_r;
  logic [2:0] out_row_r;
  logic       out_left_r;
  logic       out_right_r;

  logic       in_xfer;
  logic       out_free;
  logic       s1_go;
  logic [7:0] tbl_data;
  logic [7:0] level;
  tbl_wr_t    tbl_wr;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  // Only a tick needs the output register; everything else retires freely.
  assign s1_go    = s1_valid_r && ((s1_cmd_r != CMD_TICK) || out_free);
  assign in_chan.ready = !s1_valid_r || s1_go;

  assign cfg_chan.ready = 1'b1;

  // Table write goes in at the accept edge; a sample right behind it
  // reads the new entry at its own accept edge.
  assign tbl_wr.en   = in_xfer && (in_chan.cmd == CMD_TABLE_WR)
                       && (32'(in_chan.table_index) < TABLE_DEPTH);
  assign tbl_wr.addr = TBL_AW'(in_chan.table_index);
  assign tbl_wr.data = in_chan.sample;

  slm_log_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_en   (in_xfer && (in_chan.cmd == CMD_SAMPLE)),
    .rd_addr (TBL_AW'(in_chan.sample)),
    .rd_data (tbl_data)
  );

  // Raw values past the table end read full scale.
  assign level = (32'(s1_sample_r) >= TABLE_DEPTH) ? LEVEL_FULL : tbl_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_samples_r <= DWELL_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      dwell_samples_r <= cfg_chan.dwell_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= in_chan.cmd;
      s1_sample_r <= in_chan.sample;
    end
  end

  always_comb begin
    logic [7:0] src_l;
    logic [7:0] src_r;
    logic [7:0] bar;
    on_right_nxt    = on_right_r;
    dwell_count_nxt = dwell_count_r;
    left_bar_nxt    = left_bar_r;
    right_bar_nxt   = right_bar_r;
    left_shift_nxt  = left_shift_r;
    right_shift_nxt = right_shift_r;
    scan_row_nxt    = scan_row_r;
    src_l           = (scan_row_r == 3'd0) ? left_bar_r  : left_shift_r;
    src_r           = (scan_row_r == 3'd0) ? right_bar_r : right_shift_r;
    bar             = bar_of(level);
    if (s1_go) begin
      unique case (s1_cmd_r)
        CMD_TABLE_WR: begin
        end
        CMD_SAMPLE: begin
          // Switch channel once the dwell is used up; unless the dwell is zero, the
          // first sample after each switch (and after reset) only arms the count.
          if (dwell_count_r >= dwell_samples_r) begin
            dwell_count_nxt = 8'd0;
            on_right_nxt    = !on_right_r;
            if (!on_right_r) right_bar_nxt = bar;
            else             left_bar_nxt  = bar;
          end else if (dwell_count_r == 8'd0) begin
            dwell_count_nxt = 8'd1;
          end else begin
            dwell_count_nxt = dwell_count_r + 8'd1;
            if (on_right_r) right_bar_nxt = bar;
            else            left_bar_nxt  = bar;
          end
        end
        CMD_TICK: begin
          // Row 0 reloads the shifters from the bars.
          left_shift_nxt  = src_l >> 1;
          right_shift_nxt = src_r >> 1;
          scan_row_nxt    = scan_row_r + 3'd1;
        end
        CMD_FORCE: begin
          left_bar_nxt  = bar_of(s1_sample_r);
          right_bar_nxt = bar_of(s1_sample_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_right_r    <= 1'b0;
      dwell_count_r <= 8'd0;
      left_bar_r    <= 8'd0;
      right_bar_r   <= 8'd0;
      left_shift_r  <= 8'd0;
      right_shift_r <= 8'd0;
      scan_row_r    <= 3'd0;
    end else begin
      on_right_r    <= on_right_nxt;
      dwell_count_r <= dwell_count_nxt;
      left_bar_r    <= left_bar_nxt;
      right_bar_r   <= right_bar_nxt;
      left_shift_r  <= left_shift_nxt;
      right_shift_r <= right_shift_nxt;
      scan_row_r    <= scan_row_nxt;
    end
  end

  // Output register: loaded by a retiring tick, cleared by a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && (s1_cmd_r == CMD_TICK)) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_cmd_r == CMD_TICK)) begin
      out_row_r   <= scan_row_r;
      out_left_r  <= (scan_row_r == 3'd0) ? left_bar_r[0]  : left_shift_r[0];
      out_right_r <= (scan_row_r == 3'd0) ? right_bar_r[0] : right_shift_r[0];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row_select    = out_row_r;
  assign out_chan.left_segment  = out_left_r;
  assign out_chan.right_segment = out_right_r;

endmodule

[rtl/core/slm_log_table.sv]
// Loadable log table: one write port, one read port with registered data.
// Depends on slm_pkg.
module slm_log_table import slm_pkg::*; (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic              rd_en,
  input  logic [TBL_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [TABLE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
